### sv/mqtt_packet_deframer_defines.svh
// Assertion macros used by the deframer RTL (mpd_core).
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef MQTT_PACKET_DEFRAMER_DEFINES_SVH
`define MQTT_PACKET_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mpd_pkg.sv
// Shared types and constants for the MQTT packet deframer.
// No dependencies; imported by mpd_core, mqtt_packet_deframer and the testbench.
`timescale 1ns / 1ps

package mpd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 16;
  localparam int unsigned LenW    = 28;
  localparam int unsigned HdrLenW = 3;
  // Byte position within a packet: 1 + 4 + 2^28 - 1 fits in 29 bits
  localparam int unsigned CountW  = 29;

  localparam logic [3:0]         TypePublish = 4'd3;
  localparam logic [HdrLenW-1:0] MaxLenBytes = 3'd4;
  localparam logic [IndexW-1:0]  BufSizeRst  = 16'd256;

  // One result per received byte
  typedef struct packed {
    logic [ByteW-1:0]   data_byte;
    logic [IndexW-1:0]  byte_index;
    logic               stored;
    logic [3:0]         packet_type;
    logic               is_publish;
    logic [HdrLenW-1:0] header_length;
    logic [LenW-1:0]    remaining_length;
    logic [IndexW-1:0]  topic_length;
    logic               last;
    logic               accepted;
    logic [IndexW-1:0]  packet_length;
    logic               encoding_error;
  } mpd_result_t;

endpackage

### sv/mpd_core.sv
// Per-byte framing state and decode of the MQTT fixed header.
// Depends on mpd_pkg and mqtt_packet_deframer_defines.svh.
`timescale 1ns / 1ps
`include "mqtt_packet_deframer_defines.svh"

module mpd_core import mpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [ByteW-1:0]  byte_i,
  input  logic [IndexW-1:0] buf_size_i,
  output mpd_result_t       res_o
);

  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_LENGTH   = 3'd1;
  localparam logic [2:0] PH_TOPIC_HI = 3'd2;
  localparam logic [2:0] PH_TOPIC_LO = 3'd3;
  localparam logic [2:0] PH_BODY     = 3'd4;

  logic [2:0]         phase_q, phase_d;
  logic [3:0]         type_q, type_c;
  logic [LenW-1:0]    accum_q, accum_c, accum_d, len_bits;
  logic [HdrLenW-1:0] cnt_q, cnt_c, cnt_d;
  logic [IndexW-1:0]  stored_q, stored_c, stored_d;
  logic [CountW-1:0]  total_q, total_c, total_d;
  logic [LenW-1:0]    body_q, body_c, body_d;
  logic [IndexW-1:0]  topic_q, topic_c, topic_d;
  logic               pub, st, last, err, acc;

  // Header byte starts a fresh packet context
  always_comb begin
    if (phase_q == PH_HEADER) begin
      type_c   = byte_i[7:4];
      accum_c  = '0;
      cnt_c    = '0;
      stored_c = '0;
      total_c  = '0;
      body_c   = '0;
      topic_c  = '0;
    end else begin
      type_c   = type_q;
      accum_c  = accum_q;
      cnt_c    = cnt_q;
      stored_c = stored_q;
      total_c  = total_q;
      body_c   = body_q;
      topic_c  = topic_q;
    end
  end

  // Position the next 7-bit length group
  always_comb begin
    unique case (cnt_c[1:0])
      2'd0: len_bits = {21'd0, byte_i[6:0]};
      2'd1: len_bits = {14'd0, byte_i[6:0], 7'd0};
      2'd2: len_bits = {7'd0, byte_i[6:0], 14'd0};
      2'd3: len_bits = {byte_i[6:0], 21'd0};
    endcase
  end

  // Store decision and counters
  assign pub      = (type_c == TypePublish);
  assign st       = total_c < {{(CountW-IndexW){1'b0}}, buf_size_i};
  assign stored_d = stored_c + {{(IndexW-1){1'b0}}, st};
  assign total_d  = total_c + {{(CountW-1){1'b0}}, 1'b1};
  // total after this byte <= buffer size is the same test as st
  assign acc      = last && !err && st;

  // Phase sequencing
  always_comb begin
    phase_d = phase_q;
    accum_d = accum_c;
    cnt_d   = cnt_c;
    body_d  = body_c;
    topic_d = topic_c;
    last    = 1'b0;
    err     = 1'b0;
    unique case (phase_q)
      PH_HEADER: begin
        phase_d = PH_LENGTH;
      end
      PH_LENGTH: begin
        accum_d = accum_c | len_bits;
        cnt_d   = cnt_c + 3'd1;
        if (byte_i[7]) begin
          if (cnt_d >= MaxLenBytes) begin
            err  = 1'b1;
            last = 1'b1;
          end
        end else if (pub) begin
          phase_d = PH_TOPIC_HI;
        end else begin
          body_d = accum_d;
          if (accum_d == '0) begin
            last = 1'b1;
          end else begin
            phase_d = PH_BODY;
          end
        end
      end
      PH_TOPIC_HI: begin
        topic_d = {byte_i, 8'h00};
        phase_d = PH_TOPIC_LO;
      end
      PH_TOPIC_LO: begin
        topic_d = topic_c | {8'h00, byte_i};
        if (accum_c > 28'd2) begin
          body_d  = accum_c - 28'd2;
          phase_d = PH_BODY;
        end else begin
          body_d = '0;
          last   = 1'b1;
        end
      end
      default: begin
        if (body_c != '0) begin
          body_d = body_c - 28'd1;
        end
        if (body_c <= 28'd1) begin
          last = 1'b1;
        end
      end
    endcase
    if (last) begin
      phase_d = PH_HEADER;
    end
  end

  // Result fields
  always_comb begin
    res_o.data_byte        = byte_i;
    res_o.byte_index       = total_c[IndexW-1:0];
    res_o.stored           = st;
    res_o.packet_type      = type_c;
    res_o.is_publish       = pub;
    res_o.header_length    = cnt_d;
    res_o.remaining_length = accum_d;
    res_o.topic_length     = topic_d;
    res_o.last             = last;
    res_o.accepted         = acc;
    res_o.packet_length    = acc ? stored_d : '0;
    res_o.encoding_error   = err;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      type_q   <= '0;
      accum_q  <= '0;
      cnt_q    <= '0;
      stored_q <= '0;
      total_q  <= '0;
      body_q   <= '0;
      topic_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      type_q   <= type_c;
      accum_q  <= accum_d;
      cnt_q    <= cnt_d;
      stored_q <= stored_d;
      total_q  <= total_d;
      body_q   <= body_d;
      topic_q  <= topic_d;
    end
  end

  `MPD_ASSERT_NXT(a_last_restarts, step_i && res_o.last, phase_q == PH_HEADER,
                  "packet end did not return to header phase")
  `MPD_ASSERT_IMP(a_err_ends_drop, step_i && res_o.encoding_error,
                  res_o.last && !res_o.accepted && (res_o.packet_length == '0),
                  "encoding error not reported as dropped packet end")
  `MPD_ASSERT_IMP(a_len_cnt_range, phase_q == PH_LENGTH, cnt_q < MaxLenBytes,
                  "length byte count out of range in length phase")
  `MPD_ASSERT_IMP(a_body_nonzero, phase_q == PH_BODY, body_q != '0,
                  "body phase with nothing left to receive")

endmodule

### sv/mqtt_packet_deframer.sv
// Top level of the MQTT packet deframer: input register, decode core, result register
// and the buffer_size configuration register. Depends on mpd_pkg and mpd_core.
`timescale 1ns / 1ps

// Splits a byte stream into MQTT control packets. Each accepted byte gives exactly one
// result transaction after passing through the input register and then the result
// register, and a new byte is taken in every cycle while in_stall_o is low: the whole
// per-byte update of the header, varint length and counters is one register-to-register
// step in mpd_core. Back-pressure on the result side stalls the input only when both
// registers are full. buffer_size resets to 256 and is written through the cfg channel,
// which is always ready; write it only while no transaction is in flight.
module mqtt_packet_deframer import mpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [IndexW-1:0]  cfg_data_i,
  // received bytes
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   data_byte_o,
  output logic [IndexW-1:0]  byte_index_o,
  output logic               stored_o,
  output logic [3:0]         packet_type_o,
  output logic               is_publish_o,
  output logic [HdrLenW-1:0] header_length_o,
  output logic [LenW-1:0]    remaining_length_o,
  output logic [IndexW-1:0]  topic_length_o,
  output logic               last_o,
  output logic               accepted_o,
  output logic [IndexW-1:0]  packet_length_o,
  output logic               encoding_error_o
);

  logic [IndexW-1:0] buf_size_q;
  logic              in_vld_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              out_vld_q;
  mpd_result_t       out_q, res;
  logic              advance, in_accept;

  // Handshake: the input register moves on when the result register frees up
  assign cfg_ready_o = 1'b1;
  assign advance     = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && out_vld_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= BufSizeRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      buf_size_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  mpd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (in_byte_q),
    .buf_size_i (buf_size_q),
    .res_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign data_byte_o        = out_q.data_byte;
  assign byte_index_o       = out_q.byte_index;
  assign stored_o           = out_q.stored;
  assign packet_type_o      = out_q.packet_type;
  assign is_publish_o       = out_q.is_publish;
  assign header_length_o    = out_q.header_length;
  assign remaining_length_o = out_q.remaining_length;
  assign topic_length_o     = out_q.topic_length;
  assign last_o             = out_q.last;
  assign accepted_o         = out_q.accepted;
  assign packet_length_o    = out_q.packet_length;
  assign encoding_error_o   = out_q.encoding_error;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for mqtt_packet_deframer: random and directed packet streams,
// a per-byte decode predictor and a result checker. Depends on mpd_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import mpd_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned GapMax     = 13;

  typedef enum logic [2:0] {
    PhHeader,
    PhLength,
    PhTopicHi,
    PhTopicLo,
    PhBody
  } rx_phase_e;

  // DUT connections, all driven from time zero
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [IndexW-1:0]  cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [ByteW-1:0]   rx_byte_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  logic [ByteW-1:0]   data_byte_o;
  logic [IndexW-1:0]  byte_index_o;
  logic               stored_o;
  logic [3:0]         packet_type_o;
  logic               is_publish_o;
  logic [HdrLenW-1:0] header_length_o;
  logic [LenW-1:0]    remaining_length_o;
  logic [IndexW-1:0]  topic_length_o;
  logic               last_o;
  logic               accepted_o;
  logic [IndexW-1:0]  packet_length_o;
  logic               encoding_error_o;

  // Predictor state: mirrors the deframer after every accepted byte
  rx_phase_e   ph        = PhHeader;
  logic [7:0]  hdr       = '0;
  logic [27:0] len_acc   = '0;
  logic [2:0]  len_cnt   = '0;
  logic [15:0] st_cnt    = '0;
  logic [31:0] tot_cnt   = '0;
  logic [31:0] body_left = '0;
  logic [15:0] topic_len = '0;
  logic [15:0] buf_size  = BufSizeRst;

  mpd_result_t decoded_q[$];

  int unsigned cycles           = 0;
  int unsigned mismatches       = 0;
  int unsigned results_seen     = 0;
  int unsigned sent_bytes       = 0;
  int unsigned sink_hold_cycles = 0;
  bit          tx_idle_on       = 1'b1;
  bit          rx_idle_on       = 1'b1;

  mqtt_packet_deframer u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .data_byte_o        (data_byte_o),
    .byte_index_o       (byte_index_o),
    .stored_o           (stored_o),
    .packet_type_o      (packet_type_o),
    .is_publish_o       (is_publish_o),
    .header_length_o    (header_length_o),
    .remaining_length_o (remaining_length_o),
    .topic_length_o     (topic_length_o),
    .last_o             (last_o),
    .accepted_o         (accepted_o),
    .packet_length_o    (packet_length_o),
    .encoding_error_o   (encoding_error_o)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench failed");
      $finish;
    end
  end

  // Decode one received byte: updates the predictor state, returns the expected result
  function automatic mpd_result_t decode_rx_byte(input logic [7:0] b);
    mpd_result_t r;
    logic        pub;
    logic        st;
    logic        fin;
    logic        err;
    logic [31:0] idx;
    if (ph == PhHeader) begin
      hdr       = b;
      len_acc   = '0;
      len_cnt   = '0;
      st_cnt    = '0;
      tot_cnt   = '0;
      body_left = '0;
      topic_len = '0;
    end
    pub = (hdr[7:4] == TypePublish);
    idx = tot_cnt;
    st  = (idx < 32'(buf_size));
    if (st) st_cnt = st_cnt + 16'd1;
    tot_cnt = tot_cnt + 32'd1;
    fin = 1'b0;
    err = 1'b0;

    case (ph)
      PhHeader: ph = PhLength;
      PhLength: begin
        // 7 bits per length byte, least significant group first
        len_acc = len_acc | (28'(b[6:0]) << (7 * len_cnt[1:0]));
        len_cnt = len_cnt + 3'd1;
        if (b[7]) begin
          if (len_cnt >= MaxLenBytes) begin
            err = 1'b1;
            fin = 1'b1;
          end
        end else if (pub) begin
          ph = PhTopicHi;
        end else begin
          body_left = 32'(len_acc);
          if (body_left == 0) fin = 1'b1;
          else ph = PhBody;
        end
      end
      PhTopicHi: begin
        topic_len = {b, 8'h00};
        ph        = PhTopicLo;
      end
      PhTopicLo: begin
        topic_len[7:0] = b;
        // topic bytes count against the remaining length, floor at zero
        body_left = (len_acc > 28'd2) ? 32'(len_acc) - 32'd2 : 32'd0;
        if (body_left == 0) fin = 1'b1;
        else ph = PhBody;
      end
      default: begin
        if (body_left > 0) body_left = body_left - 32'd1;
        if (body_left == 0) fin = 1'b1;
      end
    endcase

    r.accepted      = 1'b0;
    r.packet_length = '0;
    if (fin) begin
      if (!err && tot_cnt <= 32'(buf_size)) begin
        r.accepted      = 1'b1;
        r.packet_length = st_cnt;
      end
      ph = PhHeader;
    end

    r.data_byte        = b;
    r.byte_index       = idx[15:0];
    r.stored           = st;
    r.packet_type      = hdr[7:4];
    r.is_publish       = pub;
    r.header_length    = len_cnt;
    r.remaining_length = len_acc;
    r.topic_length     = topic_len;
    r.last             = fin;
    r.encoding_error   = err;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  // Result checking first, then prediction for the byte taken at the same edge
  always @(posedge clk_i) begin
    mpd_result_t got;
    mpd_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {data_byte_o, byte_index_o, stored_o, packet_type_o, is_publish_o,
               header_length_o, remaining_length_o, topic_length_o, last_o,
               accepted_o, packet_length_o, encoding_error_o};
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result, data_byte %02h", got.data_byte));
        end else begin
          want = decoded_q.pop_front();
          compare_field("data_byte", 32'(got.data_byte), 32'(want.data_byte));
          compare_field("byte_index", 32'(got.byte_index), 32'(want.byte_index));
          compare_field("stored", 32'(got.stored), 32'(want.stored));
          compare_field("packet_type", 32'(got.packet_type), 32'(want.packet_type));
          compare_field("is_publish", 32'(got.is_publish), 32'(want.is_publish));
          compare_field("header_length", 32'(got.header_length), 32'(want.header_length));
          compare_field("remaining_length", 32'(got.remaining_length),
                        32'(want.remaining_length));
          compare_field("topic_length", 32'(got.topic_length), 32'(want.topic_length));
          compare_field("last", 32'(got.last), 32'(want.last));
          compare_field("accepted", 32'(got.accepted), 32'(want.accepted));
          compare_field("packet_length", 32'(got.packet_length), 32'(want.packet_length));
          compare_field("encoding_error", 32'(got.encoding_error),
                        32'(want.encoding_error));
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_o) decoded_q.push_back(decode_rx_byte(rx_byte_i));
    end
  end

  // Result side: random stall per transaction, plus long hold-offs on request
  initial begin : result_sink
    int unsigned wait_n;
    forever begin
      if (sink_hold_cycles > 0) begin
        wait_n           = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        wait_n = rx_idle_on ? $urandom_range(0, GapMax) : 0;
        if ($urandom_range(0, 31) == 0) rx_idle_on = !rx_idle_on;
      end
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && sink_hold_cycles == 0);
    end
  end

  // Offer one byte after a random gap and wait until it is taken
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, GapMax) : 0;
    if ($urandom_range(0, 31) == 0) tx_idle_on = !tx_idle_on;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= value;
    do @(posedge clk_i); while (in_stall_o);
    sent_bytes++;
  endtask

  // Stop offering bytes and wait for every outstanding result
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (decoded_q.size() != 0);
  endtask

  task automatic write_buffer_size(input logic [15:0] value);
    wait_all_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    buf_size = value;
  endtask

  // Well-formed packet; len_bytes > minimal pads the varint with continuation bytes
  task automatic send_packet(input logic [7:0] hdr_b, input int unsigned rem,
                             input int unsigned len_bytes, input logic [15:0] topic);
    int unsigned n;
    int unsigned body;
    logic [7:0]  grp;
    n = (rem < 128) ? 1 : (rem < 16384) ? 2 : (rem < 2097152) ? 3 : 4;
    if (len_bytes > n) n = len_bytes;
    send_byte(hdr_b);
    for (int unsigned i = 0; i < n; i++) begin
      grp    = 8'((rem >> (7 * i)) & 32'd127);
      grp[7] = (i < n - 1);
      send_byte(grp);
    end
    if (hdr_b[7:4] == TypePublish) begin
      send_byte(topic[15:8]);
      send_byte(topic[7:0]);
      body = (rem > 2) ? rem - 2 : 0;
    end else begin
      body = rem;
    end
    repeat (body) send_byte(8'($urandom));
  endtask

  // Four length bytes all flagged to continue: an encoding error
  task automatic send_bad_length(input logic [7:0] hdr_b);
    send_byte(hdr_b);
    repeat (4) send_byte(8'h80 | 8'($urandom_range(0, 127)));
  endtask

  task automatic send_random_packet();
    logic [7:0]  hdr_b;
    int unsigned rem;
    int unsigned pick;
    int unsigned pad;
    hdr_b = ($urandom_range(0, 99) < 40) ? {TypePublish, 4'($urandom)} : 8'($urandom);
    pick  = $urandom_range(0, 99);
    pad   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 1;
    if (pick < 8) begin
      send_bad_length(hdr_b);
    end else begin
      if (pick < 60) rem = $urandom_range(0, 12);
      else if (pick < 85) rem = $urandom_range(0, 40);
      else if (buf_size <= 300) rem = $urandom_range(buf_size > 8 ? buf_size - 8 : 0,
                                                      buf_size + 2);
      else rem = $urandom_range(100, 200);
      send_packet(hdr_b, rem, pad, 16'($urandom));
    end
  endtask

  // Directed: empty bodies, short PUBLISH, padded length, encoding error
  task automatic test_directed();
    send_packet(8'h10, 0, 1, 16'h0000);
    send_packet(8'h30, 0, 1, 16'hFF00);
    send_packet(8'h32, 5, 1, 16'h00FF);
    send_packet(8'hF0, 2, 4, 16'h0000);
    send_bad_length(8'hC0);
  endtask

  // Smallest buffer: packets right at, and one byte over, capacity
  task automatic test_buffer_min();
    int unsigned target;
    write_buffer_size(16'd8);
    send_packet(8'h20, 6, 1, 16'h0000);
    send_packet(8'h21, 7, 1, 16'h0000);
    send_packet(8'h35, 6, 1, 16'hA55A);
    send_packet(8'h3B, 7, 1, 16'h5AA5);
    send_bad_length(8'h3F);
    target = sent_bytes + 80;
    while (sent_bytes < target) send_random_packet();
  endtask

  // Largest buffer: nothing is ever dropped for size
  task automatic test_buffer_max();
    int unsigned target;
    write_buffer_size(16'hFFFF);
    send_packet(8'h90, 150, 2, 16'h0000);
    target = sent_bytes + 80;
    while (sent_bytes < target) send_random_packet();
  endtask

  // Result side holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    int unsigned target;
    write_buffer_size(16'd24);
    sink_hold_cycles = 300;
    target = sent_bytes + 60;
    while (sent_bytes < target) send_random_packet();
    wait_all_results();
  endtask

  // Random packet streams over several buffer sizes
  task automatic test_random_sizes();
    int unsigned target;
    logic [15:0] size_sel;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: size_sel = 16'd8;
        1: size_sel = 16'hFFFF;
        2: size_sel = 16'($urandom_range(9, 64));
        3: size_sel = 16'($urandom_range(65, 300));
        4: size_sel = BufSizeRst;
        default: size_sel = 16'($urandom_range(8, 65535));
      endcase
      write_buffer_size(size_sel);
      target = sent_bytes + 230;
      while (sent_bytes < target) send_random_packet();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_buffer_min();
    test_buffer_max();
    test_backpressure();
    test_random_sizes();
    wait_all_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
